[hdl/rbw_pkg.sv]
// Shared types and constants for the byte ring buffer with DMA window.
// Used by every module of the block; depends on nothing else.
package rbw_pkg;

    localparam int DEPTH_DEF    = 256;
    localparam int MAX_PEEK_DEF = 64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd1;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_DMA     = 3'd4,
        OP_ADV_RD  = 3'd5,
        OP_ADV_WR  = 3'd6,
        OP_SET_POS = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_EMIT,
        S_PEEK
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [7:0] count;
        logic [7:0] position;
        logic [7:0] peek_n;
    } t_req;

    typedef struct packed {
        logic [7:0]  data_out;
        logic [7:0]  occupancy;
        logic [7:0]  free_space;
        logic        full_res;
        logic        empty_res;
        logic [31:0] dma_address;
        logic [8:0]  dma_length;
        logic [7:0]  peek_end;
        logic        last;
    } t_res;

endpackage

[hdl/byte_ring_buffer_with_dma_window_core.sv]
// Top level of the byte ring buffer with DMA window.
// Depends on rbw_pkg, rbw_front, rbw_back (with rbw_mod) and rbw_outq.
//
// Requests enter through a queue port: drive the fields and raise push; a
// request is taken on a clock edge where push is high and full is low.
// Results leave through a queue port: while empty is low the oldest result is
// on the o_ ports, and it is taken on an edge where pop is high.
// Registers (capacity, buffer base) are written over the cfg channel; the user
// must write them only while no request is in flight, which the block does not
// enforce. Writing capacity clears both indices. Each request passes a two-entry
// request queue, then the execution sequencer. Push, pop, clear, DMA query and
// set write position go from the idle state through the emit state, which pushes
// their result into the result queue. Advance first runs in the shared bit-serial
// remainder unit; a peek runs there too and then yields one byte per cycle while
// the result queue is not full. The single sequencer sets the request rate.
// When the receiver stalls, two results wait in the result queue, then the
// sequencer holds, and then the request queue fills and raises full.
// Reset (synchronous, active low) clears both indices, empties the queues and
// sets capacity to its maximum; the byte store is left uninitialized.
module byte_ring_buffer_with_dma_window_core #(
    parameter int DEPTH    = rbw_pkg::DEPTH_DEF,
    parameter int MAX_PEEK = rbw_pkg::MAX_PEEK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_count,
    input  logic [7:0]  i_position,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_out,
    output logic [7:0]  o_occupancy,
    output logic [7:0]  o_free_space,
    output logic        o_full_res,
    output logic        o_empty_res,
    output logic [31:0] o_dma_address,
    output logic [8:0]  o_dma_length,
    output logic [7:0]  o_peek_end,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [rbw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import rbw_pkg::*;

    t_req req;
    logic req_valid, req_take;
    t_res res_back, res_out;
    logic res_push, res_full;

    assign o_cfg_ready = 1'b1;

    rbw_front #(
        .MAX_PEEK (MAX_PEEK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_data      (i_data),
        .i_count     (i_count),
        .i_position  (i_position),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_take  (req_take)
    );

    rbw_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_take  (req_take),
        .o_res       (res_back),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rbw_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res_back),
        .i_res_push (res_push),
        .o_res_full (res_full),
        .o_res      (res_out),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    assign o_data_out    = res_out.data_out;
    assign o_occupancy   = res_out.occupancy;
    assign o_free_space  = res_out.free_space;
    assign o_full_res    = res_out.full_res;
    assign o_empty_res   = res_out.empty_res;
    assign o_dma_address = res_out.dma_address;
    assign o_dma_length  = res_out.dma_length;
    assign o_peek_end    = res_out.peek_end;
    assign o_last        = res_out.last;

endmodule

[hdl/rbw_front.sv]
// Request front end: takes requests, classifies them and clamps the peek length.
// Holds a two-entry request queue toward the back end. Depends on rbw_pkg.
module rbw_front #(
    parameter int MAX_PEEK = rbw_pkg::MAX_PEEK_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [2:0]    i_req_type,
    input  logic [7:0]    i_data,
    input  logic [7:0]    i_count,
    input  logic [7:0]    i_position,
    output rbw_pkg::t_req o_req,
    output logic          o_req_valid,
    input  logic          i_req_take
);
    import rbw_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       acc;
    t_req       req_in;

    always_comb begin
        req_in.op       = t_op'(i_req_type);
        req_in.data     = i_data;
        req_in.count    = i_count;
        req_in.position = i_position;
        if (i_count == 8'd0) begin
            req_in.peek_n = 8'd1;
        end else if (i_count > 8'(MAX_PEEK)) begin
            req_in.peek_n = 8'(MAX_PEEK);
        end else begin
            req_in.peek_n = i_count;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign acc         = i_push && !o_full;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign n_cnt       = r_cnt + 2'(acc) - 2'(i_req_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
            end
            if (i_req_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= req_in;
        end
    end

endmodule

[hdl/rbw_mod.sv]
// Shared restoring remainder unit: dividend mod divisor, one bit per cycle.
// Used by the back end for advance counts and the peek end index. Uses rbw_pkg.
module rbw_mod (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [8:0] i_dividend,
    input  logic [8:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_rem
);
    import rbw_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_step;
    logic [8:0]  r_rem;
    logic [16:0] r_div;
    logic        ge;

    assign ge     = ({8'd0, r_rem} >= r_div);
    assign o_done = r_done;
    assign o_rem  = r_rem[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 4'd8;
            end else if (r_busy) begin
                r_step <= r_step - 4'd1;
                if (r_step == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The divisor starts shifted up by eight and walks down one place per step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= {i_divisor, 8'd0};
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_div[8:0];
            end
            r_div <= r_div >> 1;
        end
    end

endmodule

[hdl/rbw_back.sv]
// Execution back end: indices, byte store, configuration registers and the
// sequencer that forms result records. Depends on rbw_pkg and rbw_mod.
module rbw_back #(
    parameter int DEPTH = rbw_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rbw_pkg::t_req             i_req,
    input  logic                      i_req_valid,
    output logic                      o_req_take,
    output rbw_pkg::t_res             o_res,
    output logic                      o_res_push,
    input  logic                      i_res_full,
    input  logic                      i_cfg_we,
    input  logic [rbw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import rbw_pkg::*;

    localparam int CAP_MAX     = (DEPTH < 256) ? DEPTH : 256;
    localparam int STORE_DEPTH = CAP_MAX;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [8:0] CAP_HI = 9'(CAP_MAX);

    t_state      r_state, n_state;
    t_op         r_op, n_op;
    logic [7:0]  r_w, n_w, r_r, n_r;
    logic [7:0]  r_cur, n_cur;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_end, n_end;
    logic [8:0]  r_cap;
    logic [31:0] r_base;
    logic [7:0]  r_rdata;
    logic [7:0]  r_mem [STORE_DEPTH];

    logic        mem_we;
    logic        mod_start, mod_done;
    logic [8:0]  mod_dividend;
    logic [7:0]  mod_rem;
    logic [8:0]  cap_wr;
    logic [8:0]  occ9, free9, dlen9;
    t_res        res;

    function automatic logic [7:0] next_idx(input logic [7:0] idx, input logic [8:0] cap);
        logic [8:0] s;
        s = {1'b0, idx} + 9'd1;
        return (s >= cap) ? 8'd0 : s[7:0];
    endfunction

    rbw_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (r_cap),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // The capacity register holds the clamped value, so no later clamp is needed.
    always_comb begin
        if (i_cfg_data[8:0] < 9'd2) begin
            cap_wr = 9'd2;
        end else if (i_cfg_data[8:0] > CAP_HI) begin
            cap_wr = CAP_HI;
        end else begin
            cap_wr = i_cfg_data[8:0];
        end
    end

    // Status as it stands in the registered indices.
    always_comb begin
        if (r_w >= r_r) begin
            occ9 = {1'b0, r_w} - {1'b0, r_r};
        end else begin
            occ9 = r_cap - {1'b0, r_r} + {1'b0, r_w};
        end
        free9 = r_cap - occ9 - 9'd1;
        dlen9 = (r_w < r_r) ? (r_cap - {1'b0, r_r}) : occ9;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.op inside {OP_PEEK, OP_ADV_RD, OP_ADV_WR}) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = (r_op == OP_PEEK) ? S_PEEK : S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            S_PEEK: begin
                if (!i_res_full && (r_left == 8'd1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op         = r_op;
        n_w          = r_w;
        n_r          = r_r;
        n_cur        = r_cur;
        n_left       = r_left;
        n_end        = r_end;
        mem_we       = 1'b0;
        mod_start    = 1'b0;
        mod_dividend = {1'b0, r_r} + {1'b0, i_req.count};
        o_req_take   = 1'b0;
        o_res_push   = 1'b0;

        res.data_out    = 8'd0;
        res.occupancy   = occ9[7:0];
        res.free_space  = free9[7:0];
        res.full_res    = (next_idx(r_w, r_cap) == r_r);
        res.empty_res   = (r_w == r_r);
        res.dma_address = 32'd0;
        res.dma_length  = 9'd0;
        res.peek_end    = 8'd0;
        res.last        = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_take = 1'b1;
                    n_op       = i_req.op;
                    n_left     = i_req.peek_n;
                    case (i_req.op)
                        OP_PUSH: begin
                            mem_we = 1'b1;
                            n_w    = next_idx(r_w, r_cap);
                        end
                        OP_POP: begin
                            // The store read of the old read index lands for the result.
                            n_cur = r_r;
                            n_r   = next_idx(r_r, r_cap);
                        end
                        OP_CLEAR: begin
                            n_w = 8'd0;
                            n_r = 8'd0;
                        end
                        OP_SET_POS: begin
                            if ({1'b0, i_req.position} < r_cap) begin
                                n_w = i_req.position;
                            end
                        end
                        OP_PEEK: begin
                            mod_start    = 1'b1;
                            mod_dividend = {1'b0, r_r} + {1'b0, i_req.peek_n};
                        end
                        OP_ADV_RD: begin
                            mod_start    = 1'b1;
                            mod_dividend = {1'b0, r_r} + {1'b0, i_req.count};
                        end
                        OP_ADV_WR: begin
                            mod_start    = 1'b1;
                            mod_dividend = {1'b0, r_w} + {1'b0, i_req.count};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                n_cur = r_r;
                if (mod_done) begin
                    case (r_op)
                        OP_ADV_RD: n_r   = mod_rem;
                        OP_ADV_WR: n_w   = mod_rem;
                        default:   n_end = mod_rem;
                    endcase
                end
            end
            S_EMIT: begin
                o_res_push = !i_res_full;
                if (r_op == OP_POP) begin
                    res.data_out = r_rdata;
                end
                if (r_op == OP_DMA) begin
                    res.dma_address = r_base + {24'd0, r_r};
                    res.dma_length  = dlen9;
                end
            end
            S_PEEK: begin
                o_res_push   = !i_res_full;
                res.data_out = r_rdata;
                res.peek_end = r_end;
                res.last     = (r_left == 8'd1);
                if (!i_res_full) begin
                    n_cur  = next_idx(r_cur, r_cap);
                    n_left = r_left - 8'd1;
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we && (i_cfg_index == CFG_CAPACITY)) begin
            n_w = 8'd0;
            n_r = 8'd0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_PUSH;
            r_w     <= 8'd0;
            r_r     <= 8'd0;
            r_cur   <= 8'd0;
            r_left  <= 8'd0;
            r_end   <= 8'd0;
            r_cap   <= CAP_HI;
            r_base  <= 32'd0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_w     <= n_w;
            r_r     <= n_r;
            r_cur   <= n_cur;
            r_left  <= n_left;
            r_end   <= n_end;
            if (i_cfg_we && (i_cfg_index == CFG_CAPACITY)) begin
                r_cap <= cap_wr;
            end
            if (i_cfg_we && (i_cfg_index == CFG_BASE)) begin
                r_base <= i_cfg_data;
            end
        end
    end

    // The read address follows the next cursor, so the read data and the cursor
    // register update together; a write to that slot at the same edge leaves the old byte.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_w[AW-1:0]] <= i_req.data;
        end
        r_rdata <= r_mem[n_cur[AW-1:0]];
    end

endmodule

[hdl/rbw_outq.sv]
// Two-entry result queue between the back end and the result ports.
// Depends on rbw_pkg for the result record type.
module rbw_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rbw_pkg::t_res i_res,
    input  logic          i_res_push,
    output logic          o_res_full,
    output rbw_pkg::t_res o_res,
    output logic          o_empty,
    input  logic          i_pop
);
    import rbw_pkg::*;

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       acc, take;

    assign o_res_full = (r_cnt == 2'd2);
    assign o_empty    = (r_cnt == 2'd0);
    assign acc        = i_res_push && !o_res_full;
    assign take       = i_pop && !o_empty;
    assign o_res      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
            end
            if (take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(acc) - 2'(take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

[sim/tb_byte_ring_buffer_with_dma_window_core.sv]
// Self-checking testbench for byte_ring_buffer_with_dma_window_core: a directed table,
// then randomized request phases, compared with a ring-buffer predictor or, for typed rows, fixed results.
// Depends on rbw_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_with_dma_window_core;
    import rbw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_AT        = 80;
    localparam int HOLD_LEN       = 400;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 41;
    localparam int END_DRAIN      = 20;

    // Indexes past the register list; the block must ignore them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [31:0]          cfg_val;
        t_op                  op;
        logic [7:0]           data;
        logic [7:0]           count;
        logic [7:0]           position;
        logic                 typed;
        t_res                 res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_req_type = OP_PUSH;
    logic [7:0]  i_data = 8'd0;
    logic [7:0]  i_count = 8'd0;
    logic [7:0]  i_position = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_data_out;
    logic [7:0]  o_occupancy;
    logic [7:0]  o_free_space;
    logic        o_full_res;
    logic        o_empty_res;
    logic [31:0] o_dma_address;
    logic [8:0]  o_dma_length;
    logic [7:0]  o_peek_end;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_CAPACITY;
    logic [31:0] i_cfg_data = 32'd0;

    byte_ring_buffer_with_dma_window_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_data       (i_data),
        .i_count      (i_count),
        .i_position   (i_position),
        .empty        (empty),
        .pop          (pop),
        .o_data_out   (o_data_out),
        .o_occupancy  (o_occupancy),
        .o_free_space (o_free_space),
        .o_full_res   (o_full_res),
        .o_empty_res  (o_empty_res),
        .o_dma_address(o_dma_address),
        .o_dma_length (o_dma_length),
        .o_peek_end   (o_peek_end),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: a private copy of the ring, its pointers and registers.
    logic [7:0]  ring_mem [DEPTH_DEF];
    bit          slot_written [DEPTH_DEF];
    int          wr_ptr = 0;
    int          rd_ptr = 0;
    logic [8:0]  cap_reg = 9'd256;
    logic [31:0] base_addr = 32'd0;

    t_res new_results[$];
    t_res due_results[$];
    t_dir_row dir_rows[$];

    int  mismatches = 0;
    int  n_results = 0;
    int  items_in = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  rx_gap = 0;
    bit  tx_calm = 1'b0;
    int  idle_cycles = 0;

    function automatic int ring_cap();
        int c;
        c = int'(cap_reg);
        if (c < 2) c = 2;
        if (c > DEPTH_DEF) c = DEPTH_DEF;
        return c;
    endfunction

    function automatic int next_slot(int idx, int cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function automatic int fill_level(int cap);
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : cap - rd_ptr + wr_ptr;
    endfunction

    function automatic int peek_len(logic [7:0] c);
        if (c == 8'd0) return 1;
        if (c > MAX_PEEK_DEF) return MAX_PEEK_DEF;
        return int'(c);
    endfunction

    function automatic t_res add_status(t_res r, int cap);
        int occ;
        occ = fill_level(cap);
        r.occupancy  = 8'(occ);
        r.free_space = 8'(cap - occ - 1);
        r.full_res   = (next_slot(wr_ptr, cap) == rd_ptr);
        r.empty_res  = (wr_ptr == rd_ptr);
        return r;
    endfunction

    // True when a pop or peek would only touch slots that were written.
    function automatic bit reads_ok(t_op op, logic [7:0] c);
        int cap;
        int idx;
        int n;
        cap = ring_cap();
        idx = rd_ptr;
        if (op == OP_POP) return slot_written[idx];
        n = peek_len(c);
        for (int k = 0; k < n; k++) begin
            if (!slot_written[idx]) return 1'b0;
            idx = next_slot(idx, cap);
        end
        return 1'b1;
    endfunction

    // Apply one request to the ring and leave its results in new_results.
    task automatic ring_apply(input t_op op, input logic [7:0] d, input logic [7:0] c,
                              input logic [7:0] p);
        int   cap;
        int   n;
        int   idx;
        int   stop;
        t_res r;
        cap = ring_cap();
        r = '0;
        new_results.delete();
        case (op)
            OP_PUSH: begin
                ring_mem[wr_ptr] = d;
                slot_written[wr_ptr] = 1'b1;
                wr_ptr = next_slot(wr_ptr, cap);
            end
            OP_POP: begin
                r.data_out = ring_mem[rd_ptr];
                rd_ptr = next_slot(rd_ptr, cap);
            end
            OP_PEEK: begin
                n = peek_len(c);
                stop = rd_ptr;
                for (int k = 0; k < n; k++) stop = next_slot(stop, cap);
                idx = rd_ptr;
                for (int k = 0; k < n; k++) begin
                    r = '0;
                    r.data_out = ring_mem[idx];
                    r = add_status(r, cap);
                    r.peek_end = 8'(stop);
                    r.last = (k == n - 1);
                    new_results.push_back(r);
                    idx = next_slot(idx, cap);
                end
                return;
            end
            OP_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
            OP_DMA: begin
                r.dma_address = base_addr + 32'(rd_ptr);
                r.dma_length = (wr_ptr < rd_ptr) ? 9'(cap - rd_ptr) : 9'(fill_level(cap));
            end
            OP_ADV_RD: rd_ptr = (rd_ptr + int'(c)) % cap;
            OP_ADV_WR: wr_ptr = (wr_ptr + int'(c)) % cap;
            default: begin
                if (int'(p) < cap) wr_ptr = int'(p);
            end
        endcase
        r = add_status(r, cap);
        r.last = 1'b1;
        new_results.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string res_str(t_res r);
        return $sformatf({"dout=%h occ=%0d free=%0d full=%b empty=%b ",
                          "addr=%h len=%0d pend=%0d last=%b"},
                         r.data_out, r.occupancy, r.free_space, r.full_res, r.empty_res,
                         r.dma_address, r.dma_length, r.peek_end, r.last);
    endfunction

    function automatic t_res status_word(logic [7:0] dout, logic [7:0] occ, logic [7:0] free,
                                         logic fl, logic em, logic [31:0] addr,
                                         logic [8:0] len, logic [7:0] pend);
        t_res r;
        r = {dout, occ, free, fl, em, addr, len, pend, 1'b1};
        return r;
    endfunction

    function automatic t_dir_row req_row(t_op op, logic [7:0] d, logic [7:0] c, logic [7:0] p);
        t_dir_row row;
        row = '0;
        row.op = op;
        row.data = d;
        row.count = c;
        row.position = p;
        return row;
    endfunction

    function automatic t_dir_row typed_row(t_op op, logic [7:0] d, logic [7:0] c,
                                           logic [7:0] p, t_res res);
        t_dir_row row;
        row = req_row(op, d, c, p);
        row.typed = 1'b1;
        row.res = res;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        t_dir_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = v;
        return row;
    endfunction

    // Offer one request, wait for it to be taken, then record what it should produce.
    task automatic send_req(input t_op op, input logic [7:0] d, input logic [7:0] c,
                            input logic [7:0] p, input bit use_typed, input t_res typed_res);
        int gap;
        gap = (tx_calm || hold_left > 0) ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= op;
        i_data     <= d;
        i_count    <= c;
        i_position <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_in++;
        ring_apply(op, d, c, p);
        if (use_typed) due_results.push_back(typed_res);
        else foreach (new_results[k]) due_results.push_back(new_results[k]);
    endtask

    // Registers change only once every outstanding result has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        push <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CAPACITY) begin
            cap_reg = v[8:0];
            wr_ptr = 0;
            rd_ptr = 0;
        end else if (idx == CFG_BASE) begin
            base_addr = v;
        end
    endtask

    task automatic check_result();
        t_res got;
        t_res want;
        got = {o_data_out, o_occupancy, o_free_space, o_full_res, o_empty_res,
               o_dma_address, o_dma_length, o_peek_end, o_last};
        n_results++;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", res_str(got));
        end else begin
            want = due_results.pop_front();
            if (got.data_out !== want.data_out || got.occupancy !== want.occupancy ||
                got.free_space !== want.free_space || got.full_res !== want.full_res ||
                got.empty_res !== want.empty_res || got.dma_address !== want.dma_address ||
                got.dma_length !== want.dma_length || got.peek_end !== want.peek_end ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch", n_results);
                    $display("  exp %s", res_str(want));
                    $display("  got %s", res_str(got));
                end
            end
        end
    endtask

    // Result side: random pops, one long hold-off once enough requests are in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_result();
            if (!hold_done && items_in >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ((n_results / 40) % 4 != 3) rx_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_op        op;
        logic [7:0] d;
        logic [7:0] c;
        logic [7:0] p;
        logic [8:0] cap_val;
        logic [31:0] base_val;
        int         lim;
        int         r;

        // Reset state, capacity 256, base zero.
        dir_rows.push_back(typed_row(OP_DMA, 8'h00, 8'h00, 8'h00,
                           status_word(8'h00, 8'd0, 8'd255, 1'b0, 1'b1, 32'd0, 9'd0, 8'd0)));
        dir_rows.push_back(typed_row(OP_PUSH, 8'hFF, 8'hFF, 8'hFF,
                           status_word(8'h00, 8'd1, 8'd254, 1'b0, 1'b0, 32'd0, 9'd0, 8'd0)));
        dir_rows.push_back(typed_row(OP_PUSH, 8'h00, 8'h00, 8'h00,
                           status_word(8'h00, 8'd2, 8'd253, 1'b0, 1'b0, 32'd0, 9'd0, 8'd0)));
        dir_rows.push_back(typed_row(OP_POP, 8'h00, 8'h00, 8'h00,
                           status_word(8'hFF, 8'd1, 8'd254, 1'b0, 1'b0, 32'd0, 9'd0, 8'd0)));
        // A peek count of zero still reads one byte.
        dir_rows.push_back(typed_row(OP_PEEK, 8'h00, 8'h00, 8'h00,
                           status_word(8'h00, 8'd1, 8'd254, 1'b0, 1'b0, 32'd0, 9'd0, 8'd2)));
        dir_rows.push_back(req_row(OP_POP, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(typed_row(OP_CLEAR, 8'h00, 8'h00, 8'h00,
                           status_word(8'h00, 8'd0, 8'd255, 1'b0, 1'b1, 32'd0, 9'd0, 8'd0)));
        // Pop while empty advances anyway and leaves the ring reading as full.
        dir_rows.push_back(typed_row(OP_POP, 8'h00, 8'h00, 8'h00,
                           status_word(8'hFF, 8'd255, 8'd0, 1'b1, 1'b0, 32'd0, 9'd0, 8'd0)));
        // Push while full wraps the write pointer onto the read pointer.
        dir_rows.push_back(typed_row(OP_PUSH, 8'h5A, 8'h00, 8'h00,
                           status_word(8'h00, 8'd0, 8'd255, 1'b0, 1'b1, 32'd0, 9'd0, 8'd0)));
        dir_rows.push_back(req_row(OP_ADV_WR, 8'h00, 8'hFF, 8'h00));
        dir_rows.push_back(req_row(OP_DMA, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(req_row(OP_SET_POS, 8'h00, 8'h00, 8'hFF));
        dir_rows.push_back(req_row(OP_ADV_RD, 8'h00, 8'h00, 8'h00));
        // Smallest ring, base at the top of the address space.
        dir_rows.push_back(cfg_row(CFG_BASE, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(CFG_CAPACITY, 32'd2));
        dir_rows.push_back(typed_row(OP_DMA, 8'h00, 8'h00, 8'h00,
                           status_word(8'h00, 8'd0, 8'd1, 1'b0, 1'b1, 32'hFFFF_FFFF, 9'd0, 8'd0)));
        dir_rows.push_back(req_row(OP_PUSH, 8'h81, 8'h00, 8'h00));
        dir_rows.push_back(req_row(OP_PEEK, 8'h00, 8'hFF, 8'h00));
        dir_rows.push_back(req_row(OP_ADV_RD, 8'h00, 8'hFF, 8'h00));
        dir_rows.push_back(req_row(OP_SET_POS, 8'h00, 8'h00, 8'h01));
        dir_rows.push_back(req_row(OP_SET_POS, 8'h00, 8'h00, 8'h02));
        dir_rows.push_back(req_row(OP_DMA, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(req_row(OP_SET_POS, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(req_row(OP_DMA, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(req_row(OP_ADV_WR, 8'h00, 8'hFE, 8'h00));
        // Out-of-range capacities clamp; unknown register indexes do nothing.
        dir_rows.push_back(cfg_row(CFG_CAPACITY, 32'd0));
        dir_rows.push_back(req_row(OP_PUSH, 8'h3C, 8'h00, 8'h00));
        dir_rows.push_back(cfg_row(CFG_SPARE_A, 32'hA5A5_5A5A));
        dir_rows.push_back(cfg_row(CFG_SPARE_B, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(CFG_CAPACITY, 32'h0000_01FF));
        dir_rows.push_back(typed_row(OP_DMA, 8'h00, 8'h00, 8'h00,
                           status_word(8'h00, 8'd0, 8'd255, 1'b0, 1'b1, 32'hFFFF_FFFF, 9'd0, 8'd0)));
        dir_rows.push_back(req_row(OP_POP, 8'h00, 8'h00, 8'h00));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end else begin
                send_req(dir_rows[i].op, dir_rows[i].data, dir_rows[i].count,
                         dir_rows[i].position, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin cap_val = 9'd256;                      base_val = $urandom; end
                1: begin cap_val = 9'd2;                        base_val = 32'd0; end
                2: begin cap_val = 9'($urandom_range(3, 24));   base_val = 32'hFFFF_FFFF; end
                3: begin cap_val = 9'h1FF;                      base_val = $urandom; end
                4: begin cap_val = 9'($urandom_range(0, 511));  base_val = $urandom; end
                default: begin
                    cap_val  = 9'($urandom_range(2, 40));
                    base_val = 32'hFFFF_FF00;
                end
            endcase
            write_reg(CFG_BASE, base_val);
            write_reg(CFG_CAPACITY, {23'd0, cap_val});
            tx_calm = (ph == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                lim = ring_cap() - 1;
                if (lim > 255) lim = 255;
                d = 8'($urandom);
                c = 8'($urandom);
                p = 8'($urandom);
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    op = OP_PUSH;
                end else if (r < 60) begin
                    op = OP_POP;
                end else if (r < 72) begin
                    op = OP_PEEK;
                    r = $urandom_range(0, 99);
                    if (r < 60) c = 8'($urandom_range(1, 6));
                    else if (r < 75) c = 8'd0;
                end else if (r < 80) begin
                    op = OP_DMA;
                end else if (r < 93) begin
                    op = (r < 87) ? OP_ADV_RD : OP_ADV_WR;
                    if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(0, lim));
                end else if (r < 97) begin
                    op = OP_SET_POS;
                    if ($urandom_range(0, 3) != 0) p = 8'($urandom_range(0, lim));
                end else begin
                    op = OP_CLEAR;
                end
                // Never read a slot that has not been written yet.
                if ((op == OP_POP || op == OP_PEEK) && !reads_ok(op, c)) op = OP_PUSH;
                send_req(op, d, c, p, 1'b0, '0);
            end
        end

        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
